@@ hdl/rtwd_pkg.sv @@
// Package for the road tile way decoder: widths, register indexes,
// parse phase codes and the point records that travel down the pipeline.
// Depends on nothing; every module of the block imports it.
`default_nettype none

package rtwd_pkg;

  localparam int unsigned MaxTileBytesDef = 24576;

  localparam int unsigned LenW   = 20;
  localparam int unsigned CoordW = 32;
  localparam int unsigned OffW   = 16;
  localparam int unsigned KindW  = 3;
  localparam int unsigned CntW   = 8;
  localparam int unsigned CfgIdxW = 2;

  // Input stream: data_byte, tile_row, tile_col, tile_length packed from bit 0.
  localparam int unsigned InDataW  = 64;
  // Output stream: road_kind, point_index, point_total, point_lat, point_lon.
  localparam int unsigned OutDataW = 88;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TILE_SIZE  = 2'd0,
    CFG_LAT_ORIGIN = 2'd1,
    CFG_LON_ORIGIN = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] KIND_MAX = 8'd4;
  localparam logic [7:0] COUNT_MIN = 8'd2;

  typedef enum logic [5:0] {
    PH_CLASS = 6'b000001,
    PH_COUNT = 6'b000010,
    PH_XLO   = 6'b000100,
    PH_XHI   = 6'b001000,
    PH_YLO   = 6'b010000,
    PH_YHI   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [CntW-1:0]   index;
    logic [CntW-1:0]   total;
    logic              last;
  } pt_meta_t;

  // A parsed point with the tile base it belongs to.
  typedef struct packed {
    pt_meta_t          meta;
    logic [OffW-1:0]   x;
    logic [OffW-1:0]   y;
    logic [CoordW-1:0] lat_base;
    logic [CoordW-1:0] lon_base;
  } pt_raw_t;

  // A point after scaling, before the base is added.
  typedef struct packed {
    pt_meta_t          meta;
    logic [CoordW-1:0] lat_off;
    logic [CoordW-1:0] lon_off;
    logic [CoordW-1:0] lat_base;
    logic [CoordW-1:0] lon_base;
  } pt_scaled_t;

endpackage

`default_nettype wire

@@ hdl/road_tile_way_decoder.sv @@
// Top level of the road tile way decoder: byte parser, scaling stage and
// output register. Depends on rtwd_pkg.
//
//   channel  | direction | tdata / tuser / tlast
//   s_axis   | in        | byte, row, col, length / tile_start / -
//   m_axis   | out       | kind, index, total, lat, lon / - / way_last
//   cfg      | in        | write enable, index, 32-bit data
//
// One byte is taken per cycle unless the pipeline is stalled; a point passes
// the parse register, multiply register and add into the output register.
// The two 16x32 multipliers of the scaling stage set the cycle time.
// The tile base is formed after a tile start byte: products, then origin.
// A stalled output holds the pipeline only as far as it is full.
// Reset leaves the parser stopped until the next tile start.
`default_nettype none

module road_tile_way_decoder
  import rtwd_pkg::*;
#(
  parameter int unsigned MAX_TILE_BYTES = MaxTileBytesDef
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [7:0] data_byte, [23:8] tile_row, [39:24] tile_col, [59:40] tile_length
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // [0] tile_start
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [2:0] road_kind, [10:3] point_index, [18:11] point_total,
  // [50:19] point_lat, [82:51] point_lon
  output logic [OutDataW-1:0]      m_axis_tdata,
  output logic                     m_axis_tlast,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CoordW-1:0]   cfg_wdata_i
);

  localparam logic [LenW-1:0] LimMax = LenW'(MAX_TILE_BYTES);

  // Configuration registers.
  logic [CoordW-1:0] tile_size_q, lat_origin_q, lon_origin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_size_q  <= CoordW'(1);
      lat_origin_q <= '0;
      lon_origin_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_TILE_SIZE:  tile_size_q  <= cfg_wdata_i;
        CFG_LAT_ORIGIN: lat_origin_q <= cfg_wdata_i;
        CFG_LON_ORIGIN: lon_origin_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input fields.
  logic [7:0]      in_byte;
  logic [15:0]     in_row, in_col;
  logic [LenW-1:0] in_len;
  assign in_byte = s_axis_tdata[7:0];
  assign in_row  = s_axis_tdata[23:8];
  assign in_col  = s_axis_tdata[39:24];
  assign in_len  = s_axis_tdata[59:40];

  // Pipeline flow control.
  logic p1_v_q, p2_v_q, out_v_q;
  logic out_rdy, p2_rdy, p1_rdy, in_acc;
  assign out_rdy       = !out_v_q || m_axis_tready;
  assign p2_rdy        = !p2_v_q || out_rdy;
  assign p1_rdy        = !p1_v_q || p2_rdy;
  assign s_axis_tready = p1_rdy;
  assign in_acc        = s_axis_tvalid && p1_rdy;

  // Parser state.
  logic [LenW-1:0]   pos_q, pos_d, lim_q, lim_d;
  phase_e            phase_q, phase_d;
  logic              stop_q, stop_d;
  logic [KindW-1:0]  cls_q, cls_d;
  logic [CntW-1:0]   cnt_q, cnt_d, pt_q, pt_d;
  logic [7:0]        part_q, part_d;
  logic [OffW-1:0]   held_x_q, held_x_d;
  logic [CoordW-1:0] lat_base_q, lon_base_q;
  logic              emit;
  pt_raw_t           pt_new;

  logic [LenW-1:0]   e_pos, e_lim;
  phase_e            e_phase;
  logic              e_stop;
  logic [KindW-1:0]  e_cls;
  logic [CntW-1:0]   e_cnt, e_pt;
  logic [7:0]        e_part;
  logic [OffW-1:0]   e_held;
  logic              is_last;

  always_comb begin
    e_pos   = pos_q;
    e_lim   = lim_q;
    e_phase = phase_q;
    e_stop  = stop_q;
    e_cls   = cls_q;
    e_cnt   = cnt_q;
    e_pt    = pt_q;
    e_part  = part_q;
    e_held  = held_x_q;
    if (s_axis_tuser) begin
      e_lim   = (in_len > LimMax) ? LimMax : in_len;
      e_pos   = '0;
      e_phase = PH_CLASS;
      e_stop  = 1'b0;
      e_cls   = '0;
      e_cnt   = '0;
      e_pt    = '0;
      e_part  = '0;
      e_held  = '0;
    end

    pos_d    = e_pos;
    lim_d    = e_lim;
    phase_d  = e_phase;
    stop_d   = e_stop;
    cls_d    = e_cls;
    cnt_d    = e_cnt;
    pt_d     = e_pt;
    part_d   = e_part;
    held_x_d = e_held;
    emit     = 1'b0;
    is_last  = ({1'b0, e_pt} + 9'd1) >= {1'b0, e_cnt};

    pt_new.meta.kind  = e_cls;
    pt_new.meta.index = e_pt;
    pt_new.meta.total = e_cnt;
    pt_new.meta.last  = is_last;
    pt_new.x          = e_held;
    pt_new.y          = {in_byte, e_part};
    pt_new.lat_base   = lat_base_q;
    pt_new.lon_base   = lon_base_q;

    if (!e_stop) begin
      if (e_pos >= e_lim) begin
        stop_d = 1'b1;
      end else begin
        pos_d = e_pos + LenW'(1);
        unique case (e_phase)
          PH_CLASS: begin
            if ((21'(e_pos) + 21'd2) > 21'(e_lim) || in_byte == 8'd0
                || in_byte > KIND_MAX) begin
              stop_d = 1'b1;
              pos_d  = e_pos;
            end else begin
              cls_d   = in_byte[KindW-1:0];
              phase_d = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (in_byte < COUNT_MIN
                || (21'(e_pos) + 21'd1 + {11'd0, in_byte, 2'b00}) > 21'(e_lim)) begin
              stop_d = 1'b1;
              pos_d  = e_pos;
            end else begin
              cnt_d   = in_byte;
              pt_d    = '0;
              phase_d = PH_XLO;
            end
          end
          PH_XLO: begin
            part_d  = in_byte;
            phase_d = PH_XHI;
          end
          PH_XHI: begin
            held_x_d = {in_byte, e_part};
            phase_d  = PH_YLO;
          end
          PH_YLO: begin
            part_d  = in_byte;
            phase_d = PH_YHI;
          end
          PH_YHI: begin
            emit = 1'b1;
            if (is_last) begin
              phase_d = PH_CLASS;
              pt_d    = '0;
            end else begin
              pt_d    = e_pt + CntW'(1);
              phase_d = PH_XLO;
            end
          end
          default: begin
            stop_d = 1'b1;
            pos_d  = e_pos;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      lim_q    <= '0;
      phase_q  <= PH_CLASS;
      stop_q   <= 1'b1;
      cls_q    <= '0;
      cnt_q    <= '0;
      pt_q     <= '0;
      part_q   <= '0;
      held_x_q <= '0;
    end else if (in_acc) begin
      pos_q    <= pos_d;
      lim_q    <= lim_d;
      phase_q  <= phase_d;
      stop_q   <= stop_d;
      cls_q    <= cls_d;
      cnt_q    <= cnt_d;
      pt_q     <= pt_d;
      part_q   <= part_d;
      held_x_q <= held_x_d;
    end
  end

  // Tile base: product registered on the tile start byte, origin added in the
  // cycle after. The first point of a tile comes at least five bytes on.
  logic [CoordW-1:0] row_prod_q, col_prod_q;
  logic              base_pend_q;

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser) begin
      row_prod_q <= CoordW'(in_row) * tile_size_q;
      col_prod_q <= CoordW'(in_col) * tile_size_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_pend_q <= 1'b0;
      lat_base_q  <= '0;
      lon_base_q  <= '0;
    end else begin
      base_pend_q <= in_acc && s_axis_tuser;
      if (base_pend_q) begin
        lat_base_q <= lat_origin_q + row_prod_q;
        lon_base_q <= lon_origin_q + col_prod_q;
      end
    end
  end

  // Stage one: parsed point.
  pt_raw_t p1_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_q <= in_acc && emit;
    end
  end
  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      p1_q <= pt_new;
    end
  end

  // Stage two: offsets scaled by the tile size, keeping bits 47:16.
  logic [47:0] lat_prod, lon_prod;
  pt_scaled_t  p2_q;
  assign lat_prod = 48'(p1_q.y) * 48'(tile_size_q);
  assign lon_prod = 48'(p1_q.x) * 48'(tile_size_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_q <= p1_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (p2_rdy && p1_v_q) begin
      p2_q.meta     <= p1_q.meta;
      p2_q.lat_off  <= lat_prod[47:16];
      p2_q.lon_off  <= lon_prod[47:16];
      p2_q.lat_base <= p1_q.lat_base;
      p2_q.lon_base <= p1_q.lon_base;
    end
  end

  // Output register.
  pt_meta_t          out_meta_q;
  logic [CoordW-1:0] out_lat_q, out_lon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_rdy) begin
      out_v_q <= p2_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (out_rdy && p2_v_q) begin
      out_meta_q <= p2_q.meta;
      out_lat_q  <= p2_q.lat_base + p2_q.lat_off;
      out_lon_q  <= p2_q.lon_base + p2_q.lon_off;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tlast  = out_meta_q.last;
  assign m_axis_tdata  = {5'd0, out_lon_q, out_lat_q, out_meta_q.total,
                          out_meta_q.index, out_meta_q.kind};

endmodule

`default_nettype wire

@@ hdl/rtwd_checker.sv @@
// Port-level checker for the road tile way decoder, bound to the top level.
// Depends on rtwd_pkg.
`default_nettype none

module rtwd_checker
  import rtwd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                m_axis_tvalid,
  input wire logic                m_axis_tready,
  input wire logic [OutDataW-1:0] m_axis_tdata,
  input wire logic                m_axis_tlast
);

  logic [KindW-1:0] kind;
  logic [CntW-1:0]  idx, total;
  assign kind  = m_axis_tdata[2:0];
  assign idx   = m_axis_tdata[10:3];
  assign total = m_axis_tdata[18:11];

  // A request that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request changed while stalled");

  // The way-last mark sits exactly on the final point.
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == ({1'b0, idx} + 9'd1 == {1'b0, total})))
    else $error("way-last mark does not match point index");

  // Only valid road classes and ways of at least two points are emitted.
  a_kind_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> kind != '0 && kind <= KindW'(4) && total >= CntW'(2)
                      && idx < total)
    else $error("point with bad class, count or index");

  // Order within a way: after a non-final point comes the next index or index 0.
  a_index_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
    |-> idx == $past(idx) + CntW'(1) || idx == '0)
    else $error("point index skipped within a way");

endmodule

bind road_tile_way_decoder rtwd_checker u_rtwd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
